/* hw/rtl/kpd_pkg.sv */
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types, constants and the key code map of the keypad scanner.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int NUM_KEYS           = 12;
  localparam int TICK_WIDTH_DEFAULT = 32;
  localparam int DEBOUNCE_WIDTH     = 16;
  localparam int CODE_WIDTH         = 8;
  localparam int NOW_WIDTH          = 32;
  localparam int CFG_INDEX_WIDTH    = 2;

  localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [CODE_WIDTH-1:0]     CONFIRM_RESET  = 8'd10;
  localparam logic [CODE_WIDTH-1:0]     BACK_RESET     = 8'd11;

  localparam int KEY_STAR  = 9;
  localparam int KEY_ZERO  = 10;
  localparam int KEY_HASH  = 11;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_CONFIRM  = 2'd1,
    CFG_BACK     = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_PRESS_DB   = 2'd1,
    PH_PRESSED    = 2'd2,
    PH_RELEASE_DB = 2'd3
  } phase_t;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_TAKE = 1'b1
  } op_t;

  typedef struct packed {
    logic                  op;
    logic [NUM_KEYS-1:0]   pressed_map;
    logic [NOW_WIDTH-1:0]  now_ms;
  } in_t;

  typedef struct packed {
    logic                  event_valid;
    logic [CODE_WIDTH-1:0] event_code;
  } out_t;

  typedef struct packed {
    logic                  active;
    logic                  stop;
    logic                  blocked;
    logic [CODE_WIDTH-1:0] code;
    logic [NUM_KEYS-1:0]   map;
  } token_t;

  function automatic logic [CODE_WIDTH-1:0] key_code(
    input int                    key,
    input logic [CODE_WIDTH-1:0] confirm_code,
    input logic [CODE_WIDTH-1:0] back_code
  );
    logic [CODE_WIDTH-1:0] code;
    if (key < KEY_STAR) begin
      code = CODE_WIDTH'(key + 1);
    end else if (key == KEY_STAR) begin
      code = confirm_code;
    end else if (key == KEY_ZERO) begin
      code = '0;
    end else begin
      code = back_code;
    end
    return code;
  endfunction

endpackage

/* hw/rtl/kpd_cell.sv */
// ----------------------------------------------------------------------------
// kpd_cell
// One key of the scan chain: debounce state of the key and one token stage.
// ----------------------------------------------------------------------------
module kpd_cell
  import kpd_pkg::*;
#(
  parameter int KEY        = 0,
  parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  token_t                    tok_in,
  input  logic [TICK_WIDTH-1:0]     now,
  input  logic [DEBOUNCE_WIDTH-1:0] debounce_ms,
  input  logic [CODE_WIDTH-1:0]     confirm_code,
  input  logic [CODE_WIDTH-1:0]     back_code,
  output token_t                    tok_out
);

  phase_t                phase, phase_next;
  logic                  prev_level, prev_level_next;
  logic [TICK_WIDTH-1:0] stamp, stamp_next;
  token_t                tok_next;
  logic                  level;
  logic                  settled;
  logic                  hit;

  assign level   = !(tok_in.map[KEY] && !tok_in.blocked);
  assign settled = (now - stamp) >= TICK_WIDTH'(debounce_ms);

  always_comb begin
    phase_next      = phase;
    prev_level_next = prev_level;
    stamp_next      = stamp;
    hit             = 1'b0;
    if (tok_in.active && !tok_in.stop) begin
      prev_level_next = level;
      case (phase)
        PH_IDLE: begin
          if (!level && prev_level) begin
            phase_next = PH_PRESS_DB;
            stamp_next = now;
          end
        end
        PH_PRESS_DB: begin
          if (settled) begin
            if (!level) begin
              phase_next = PH_PRESSED;
              hit        = 1'b1;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
        PH_PRESSED: begin
          if (level && !prev_level) begin
            phase_next = PH_RELEASE_DB;
            stamp_next = now;
          end
        end
        default: begin
          if (settled) begin
            phase_next = PH_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    tok_next         = tok_in;
    tok_next.blocked = tok_in.blocked | tok_in.map[KEY];
    if (hit) begin
      tok_next.stop = 1'b1;
      tok_next.code = key_code(KEY, confirm_code, back_code);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      prev_level     <= 1'b1;
      stamp          <= '0;
      tok_out.active <= 1'b0;
    end else begin
      phase          <= phase_next;
      prev_level     <= prev_level_next;
      stamp          <= stamp_next;
      tok_out.active <= tok_next.active;
    end
    tok_out.stop    <= tok_next.stop;
    tok_out.blocked <= tok_next.blocked;
    tok_out.code    <= tok_next.code;
    tok_out.map     <= tok_next.map;
  end

endmodule

/* hw/rtl/matrix_keypad_debounce_scanner_unit.sv */
// ----------------------------------------------------------------------------
// matrix_keypad_debounce_scanner_unit
// 12-key keypad scanner: a chain of key cells walked by a token per scan.
// ----------------------------------------------------------------------------
// A scan beat keeps the block busy while its token walks the chain: it is launched
// into a register, passes the token stage of each key cell, then the event is latched.
// A scan beat that arrives while an event is pending starts no walk.
// A take beat clears the pending event; its result beat appears in the next cycle.
// Synchronous reset clears all key state and the pending event at once.
module matrix_keypad_debounce_scanner_unit
  import kpd_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  in_t                        in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output out_t                       out_data,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [DEBOUNCE_WIDTH-1:0]  cfg_data
);

  logic [DEBOUNCE_WIDTH-1:0] debounce_ms;
  logic [CODE_WIDTH-1:0]     confirm_code;
  logic [CODE_WIDTH-1:0]     back_code;
  logic                      busy;
  logic                      pending_valid;
  logic [CODE_WIDTH-1:0]     pending_code;
  logic [TICK_WIDTH-1:0]     now;
  token_t                    tok [NUM_KEYS+1];
  token_t                    launch_next;
  logic                      in_accept;
  logic                      take;
  logic                      scan_walk;
  logic                      walk_done;

  assign in_stall  = busy || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign take      = in_accept && (in_data.op == OP_TAKE);
  assign scan_walk = in_accept && (in_data.op == OP_SCAN) && !pending_valid;
  assign walk_done = tok[NUM_KEYS].active;

  always_comb begin
    launch_next         = '0;
    launch_next.active  = scan_walk;
    launch_next.map     = in_data.pressed_map;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms  <= DEBOUNCE_RESET;
      confirm_code <= CONFIRM_RESET;
      back_code    <= BACK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_ms  <= cfg_data;
        CFG_CONFIRM:  confirm_code <= cfg_data[CODE_WIDTH-1:0];
        CFG_BACK:     back_code    <= cfg_data[CODE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      pending_valid <= 1'b0;
      pending_code  <= '0;
      out_valid     <= 1'b0;
      tok[0].active <= 1'b0;
    end else begin
      tok[0].active <= launch_next.active;
      if (scan_walk) begin
        busy <= 1'b1;
      end else if (walk_done) begin
        busy <= 1'b0;
        if (tok[NUM_KEYS].stop) begin
          pending_valid <= 1'b1;
          pending_code  <= tok[NUM_KEYS].code;
        end
      end
      if (take) begin
        pending_valid <= 1'b0;
        pending_code  <= '0;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    tok[0].stop    <= launch_next.stop;
    tok[0].blocked <= launch_next.blocked;
    tok[0].code    <= launch_next.code;
    tok[0].map     <= launch_next.map;
    if (scan_walk) begin
      now <= in_data.now_ms[TICK_WIDTH-1:0];
    end
    if (take) begin
      out_data.event_valid <= pending_valid;
      out_data.event_code  <= pending_valid ? pending_code : '0;
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_cell
    kpd_cell #(
      .KEY        (k),
      .TICK_WIDTH (TICK_WIDTH)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .tok_in       (tok[k]),
      .now          (now),
      .debounce_ms  (debounce_ms),
      .confirm_code (confirm_code),
      .back_code    (back_code),
      .tok_out      (tok[k+1])
    );
  end

endmodule
